// ===== rtl/weighted_nearest_record_search_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef WEIGHTED_NEAREST_RECORD_SEARCH_TOP_MACROS_SVH
`define WEIGHTED_NEAREST_RECORD_SEARCH_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define WNRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define WNRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/wnrs_pkg.sv =====
package wnrs_pkg;

   localparam int unsigned DateW = 17;
   localparam int unsigned RateW = 32;
   localparam int unsigned NotionalW = 40;
   localparam int unsigned CountW = 11;
   localparam int unsigned DistW = 30;
   localparam logic [63:0] Bound = 64'd1000000000;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef struct packed {
      logic [DateW-1:0]     open_day;
      logic [DateW-1:0]     close_day;
      logic [DateW-1:0]     trade_date;
      logic [DateW-1:0]     trade_clock;
      logic [RateW-1:0]     coupon_rate;
      logic [NotionalW-1:0] notional;
   } record_type;

   // Saturating 64-bit add.
   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] sat_sq(input logic [63:0] a);
      sat_sq = (a[63:32] != 32'd0) ? '1 : a[31:0] * a[31:0];
   endfunction

   function automatic logic [7:0] absd8(input logic [7:0] a, input logic [7:0] b);
      absd8 = (a > b) ? a - b : b - a;
   endfunction

   // |dyear|*365 + |dmonth|*30 + |dday|
   function automatic logic [16:0] date_dist(input logic [DateW-1:0] a,
                                             input logic [DateW-1:0] b);
      logic [7:0] y;
      logic [7:0] m;
      logic [7:0] d;
      y = absd8(a[16:9], b[16:9]);
      m = absd8({4'd0, a[8:5]}, {4'd0, b[8:5]});
      d = absd8({3'd0, a[4:0]}, {3'd0, b[4:0]});
      date_dist = 17'(y * 17'd365) + 17'(m * 17'd30) + 17'(d);
   endfunction

endpackage

// ===== rtl/weighted_nearest_record_search_top.sv =====
// Nearest record search over a table held in one synchronous RAM. A write item
// (func 0) stores one record. A query item (func 1) reads the first
// min(entry_count, TABLE_ENTRIES) entries, one per cycle through the RAM read
// port, into a distance, square, sum and compare pipeline, and returns one
// item with the first strictly smallest sum below 1000000000 (or index 0,
// distance 1000000000, none_closer set).
// One item is worked at a time; the next is taken once the result has left.
module weighted_nearest_record_search_top
   import wnrs_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CountW-1:0]    csr_entry_count,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [9:0]           req_entry_slot,
   input  logic [DateW-1:0]     req_open_day,
   input  logic [DateW-1:0]     req_close_day,
   input  logic [DateW-1:0]     req_trade_date,
   input  logic [DateW-1:0]     req_trade_clock,
   input  logic signed [RateW-1:0] req_coupon_rate,
   input  logic [NotionalW-1:0] req_notional,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [9:0]           rsp_nearest_index,
   output logic [DistW-1:0]     rsp_best_score,
   output logic                 rsp_none_closer
);

   localparam int unsigned AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned PipeW = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   record_type table_mem [TABLE_ENTRIES];
   record_type rd_data_ff;

   state_type state_ff;
   logic [CountW-1:0] entry_count_ff;
   record_type query_ff;
   logic [CntW-1:0] scan_cnt_ff;
   logic [CntW-1:0] scan_end_ff;
   logic [AddrW-1:0] rd_idx_ff;
   logic rd_vld_ff;

   // stage 1: per-field distances
   logic s1_vld_ff;
   logic [AddrW-1:0] s1_idx_ff;
   logic [63:0] s1_start_ff, s1_end_ff, s1_time_ff, s1_rate_ff, s1_notl_ff;
   // stage 2: squares
   logic s2_vld_ff;
   logic [AddrW-1:0] s2_idx_ff;
   logic [63:0] s2_sq_ff [5];
   // stage 3: sum
   logic s3_vld_ff;
   logic [AddrW-1:0] s3_idx_ff;
   logic [63:0] s3_sum_ff;

   logic [63:0] best_ff;
   logic [AddrW-1:0] best_idx_ff;
   logic [PipeW-1:0] drain_ff;

   logic rsp_valid_ff;
   logic [9:0] rsp_index_ff;
   logic [DistW-1:0] rsp_dist_ff;
   logic rsp_none_ff;

   logic req_take;
   logic [CntW-1:0] count_clip;
   record_type req_rec;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_take = req_valid && !req_stall;

   assign req_rec = '{open_day: req_open_day, close_day: req_close_day,
                      trade_date: req_trade_date, trade_clock: req_trade_clock,
                      coupon_rate: req_coupon_rate, notional: req_notional};

   assign count_clip = ({21'd0, entry_count_ff} > 32'(TABLE_ENTRIES)) ?
                       CntW'(TABLE_ENTRIES) : CntW'(entry_count_ff);

   // Table RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (req_take && req_func == FUNC_WRITE &&
          {22'd0, req_entry_slot} < 32'(TABLE_ENTRIES)) begin
         table_mem[AddrW'(req_entry_slot)] <= req_rec;
      end
      rd_data_ff <= table_mem[AddrW'(scan_cnt_ff)];
   end

   // Distance terms from the record read last cycle.
   logic [63:0] st_dist, en_dist, tm_dist, rt_dist, nt_dist;
   logic [31:0] ra, rb;
   logic [39:0] na, nb;
   always_comb begin
      ra = query_ff.coupon_rate ^ 32'h8000_0000;
      rb = rd_data_ff.coupon_rate ^ 32'h8000_0000;
      na = query_ff.notional;
      nb = rd_data_ff.notional;
      st_dist = 64'(date_dist(query_ff.open_day, rd_data_ff.open_day));
      en_dist = 64'(date_dist(query_ff.close_day, rd_data_ff.close_day));
      tm_dist = 64'(date_dist(query_ff.trade_date, rd_data_ff.trade_date)) * 64'd86400
              + 64'(absd8({3'd0, query_ff.trade_clock[16:12]},
                          {3'd0, rd_data_ff.trade_clock[16:12]})) * 64'd3600
              + 64'(absd8({2'd0, query_ff.trade_clock[11:6]},
                          {2'd0, rd_data_ff.trade_clock[11:6]})) * 64'd60
              + 64'(absd8({2'd0, query_ff.trade_clock[5:0]},
                          {2'd0, rd_data_ff.trade_clock[5:0]}));
      rt_dist = 64'((ra > rb) ? ra - rb : rb - ra);
      nt_dist = 64'((na > nb) ? na - nb : nb - na);
   end

   logic [63:0] sum_in;
   always_comb begin
      sum_in = 64'd0;
      if (query_ff.open_day[16:9] != 8'd0) sum_in = sat_add(sum_in, s2_sq_ff[0]);
      if (query_ff.close_day[16:9] != 8'd0) sum_in = sat_add(sum_in, s2_sq_ff[1]);
      if (query_ff.trade_date[16:9] != 8'd0) sum_in = sat_add(sum_in, s2_sq_ff[2]);
      if (query_ff.coupon_rate != '0) sum_in = sat_add(sum_in, s2_sq_ff[3] >> 32);
      if (query_ff.notional != '0) sum_in = sat_add(sum_in, s2_sq_ff[4]);
   end

   // Pipeline payload (no reset).
   always_ff @(posedge clock) begin
      if (req_take) query_ff <= req_rec;
      s1_idx_ff <= rd_idx_ff;
      s1_start_ff <= st_dist;
      s1_end_ff <= en_dist;
      s1_time_ff <= tm_dist;
      s1_rate_ff <= rt_dist;
      s1_notl_ff <= nt_dist;
      s2_idx_ff <= s1_idx_ff;
      s2_sq_ff[0] <= sat_sq(s1_start_ff);
      s2_sq_ff[1] <= sat_sq(s1_end_ff);
      s2_sq_ff[2] <= sat_sq(s1_time_ff);
      s2_sq_ff[3] <= sat_sq(s1_rate_ff);
      s2_sq_ff[4] <= sat_sq(s1_notl_ff);
      s3_idx_ff <= s2_idx_ff;
      s3_sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_count_ff <= '0;
         scan_cnt_ff <= '0;
         scan_end_ff <= '0;
         rd_idx_ff <= '0;
         rd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         best_ff <= Bound;
         best_idx_ff <= '0;
         drain_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_index_ff <= '0;
         rsp_dist_ff <= '0;
         rsp_none_ff <= 1'b0;
      end else begin
         if (csr_write_enable) entry_count_ff <= csr_entry_count;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         rd_vld_ff <= (state_ff == ST_SCAN) && (scan_cnt_ff < scan_end_ff);
         rd_idx_ff <= AddrW'(scan_cnt_ff);
         s1_vld_ff <= rd_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;

         if (s3_vld_ff && s3_sum_ff < best_ff) begin
            best_ff <= s3_sum_ff;
            best_idx_ff <= s3_idx_ff;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take && req_func == FUNC_QUERY) begin
                  scan_cnt_ff <= '0;
                  scan_end_ff <= count_clip;
                  best_ff <= Bound;
                  best_idx_ff <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_cnt_ff < scan_end_ff) begin
                  scan_cnt_ff <= scan_cnt_ff + 1'b1;
               end else begin
                  drain_ff <= '1;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // wait for the pipeline to empty
               drain_ff <= drain_ff >> 1;
               if (drain_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= 10'(best_idx_ff);
                  rsp_dist_ff <= best_ff[DistW-1:0];
                  rsp_none_ff <= (best_ff == Bound);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_best_score = rsp_dist_ff;
   assign rsp_none_closer = rsp_none_ff;

endmodule

// ===== rtl/wnrs_checker.sv =====
`include "weighted_nearest_record_search_top_macros.svh"

module wnrs_checker
   import wnrs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [DistW-1:0] rsp_best_score,
   input logic             rsp_none_closer
);

   localparam logic [DistW-1:0] NoneScore = DistW'(Bound);

   logic none_shown;
   logic out_stalled;

   assign none_shown = rsp_valid && rsp_none_closer;
   assign out_stalled = rsp_valid && rsp_stall;

   `WNRS_ASSERT_IMPL(a_none_dist, clock, reset, none_shown, rsp_best_score == NoneScore)
   `WNRS_ASSERT_IMPL(a_dist_bound, clock, reset, rsp_valid, rsp_best_score <= NoneScore)
   `WNRS_ASSERT_IMPL(a_busy_out, clock, reset, rsp_valid, req_stall)
   `WNRS_ASSERT_NEXT(a_rsp_hold, clock, reset, out_stalled, rsp_valid && $stable(rsp_best_score))

endmodule

bind weighted_nearest_record_search_top wnrs_checker u_wnrs_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_best_score(rsp_best_score), .rsp_none_closer(rsp_none_closer)
);

// ===== sim/tb_weighted_nearest_record_search_top.sv =====
module tb_weighted_nearest_record_search_top
   import wnrs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Entries = 1024;
   localparam logic [63:0] NoneDist = 64'd1000000000;
   localparam int unsigned CycleLimit = 600000;

   typedef struct {
      func_type   func;
      logic [9:0] slot;
      record_type rec;
   } req_item_type;

   typedef struct {
      logic [9:0]       index;
      logic [DistW-1:0] distance;
      logic             none_closer;
   } nearest_type;

   typedef struct {
      logic         is_cfg;
      logic [10:0]  cnt;
      req_item_type item;
      logic         typed;
      nearest_type  want;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CountW-1:0]       csr_entry_count = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_func = 1'b0;
   logic [9:0]              req_entry_slot = '0;
   logic [DateW-1:0]        req_open_day = '0;
   logic [DateW-1:0]        req_close_day = '0;
   logic [DateW-1:0]        req_trade_date = '0;
   logic [DateW-1:0]        req_trade_clock = '0;
   logic signed [RateW-1:0] req_coupon_rate = '0;
   logic [NotionalW-1:0]    req_notional = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [9:0]              rsp_nearest_index;
   logic [DistW-1:0]        rsp_best_score;
   logic                    rsp_none_closer;

   weighted_nearest_record_search_top dut (
      .clock, .reset, .csr_write_enable, .csr_entry_count,
      .req_valid, .req_stall, .req_func, .req_entry_slot, .req_open_day,
      .req_close_day, .req_trade_date, .req_trade_clock, .req_coupon_rate,
      .req_notional, .rsp_valid, .rsp_stall, .rsp_nearest_index,
      .rsp_best_score, .rsp_none_closer
   );

   always #5 clock = ~clock;

   record_type  record_shadow [Entries];
   logic [10:0] scan_count = '0;
   nearest_type nearest_q [$];
   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          burst_left = 0;

   function automatic logic [63:0] abs_gap(input logic [63:0] a, input logic [63:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] square_clip(input logic [63:0] a);
      return (a > 64'hFFFF_FFFF) ? '1 : a * a;
   endfunction

   function automatic logic [63:0] day_span(input logic [16:0] a, input logic [16:0] b);
      return abs_gap(a[16:9], b[16:9]) * 365 + abs_gap(a[8:5], b[8:5]) * 30
         + abs_gap(a[4:0], b[4:0]);
   endfunction

   function automatic logic [63:0] weighted_distance(input record_type q, input record_type r);
      logic [63:0] sum;
      logic [63:0] secs;
      sum = 0;
      if (q.open_day[16:9] != 0)
         sum = add_clip(sum, square_clip(day_span(q.open_day, r.open_day)));
      if (q.close_day[16:9] != 0)
         sum = add_clip(sum, square_clip(day_span(q.close_day, r.close_day)));
      if (q.trade_date[16:9] != 0) begin
         secs = day_span(q.trade_date, r.trade_date) * 86400
            + abs_gap(q.trade_clock[16:12], r.trade_clock[16:12]) * 3600
            + abs_gap(q.trade_clock[11:6], r.trade_clock[11:6]) * 60
            + abs_gap(q.trade_clock[5:0], r.trade_clock[5:0]);
         sum = add_clip(sum, square_clip(secs));
      end
      // offset binary so the unsigned gap matches the signed one
      if (q.coupon_rate != 0)
         sum = add_clip(sum, square_clip(abs_gap(q.coupon_rate ^ 32'h8000_0000,
            r.coupon_rate ^ 32'h8000_0000)) >> 32);
      if (q.notional != 0)
         sum = add_clip(sum, square_clip(abs_gap(q.notional, r.notional)));
      return sum;
   endfunction

   function automatic nearest_type predict_nearest(input record_type q);
      nearest_type res;
      logic [63:0] best;
      logic [63:0] s;
      int          n;
      best = NoneDist;
      res.index = '0;
      n = (scan_count > Entries) ? Entries : scan_count;
      for (int i = 0; i < n; i++) begin
         s = weighted_distance(q, record_shadow[i]);
         if (s < best) begin
            best = s;
            res.index = 10'(i);
         end
      end
      res.distance = best[DistW-1:0];
      res.none_closer = (best == NoneDist);
      return res;
   endfunction

   function automatic logic [16:0] pack_date(input int y, input int m, input int d);
      return {8'(y), 4'(m), 5'(d)};
   endfunction

   function automatic record_type random_record();
      record_type r;
      if ($urandom_range(0, 4) == 0) begin
         r.open_day = 17'($urandom);
         r.close_day = 17'($urandom);
         r.trade_date = 17'($urandom);
         r.trade_clock = 17'($urandom);
      end else begin
         r.open_day = pack_date($urandom_range(1, 255), $urandom_range(0, 11),
            $urandom_range(1, 31));
         r.close_day = pack_date($urandom_range(1, 255), $urandom_range(0, 11),
            $urandom_range(1, 31));
         r.trade_date = pack_date($urandom_range(1, 255), $urandom_range(0, 11),
            $urandom_range(1, 31));
         r.trade_clock = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
            6'($urandom_range(0, 59))};
      end
      r.coupon_rate = $urandom;
      r.notional = 40'({$urandom, $urandom});
      return r;
   endfunction

   // near copy of a loaded entry, some fields dropped so terms go absent
   function automatic record_type near_query(input record_type r);
      record_type q;
      q = r;
      q.open_day[4:0] = q.open_day[4:0] ^ 5'($urandom_range(0, 3));
      q.close_day[4:0] = q.close_day[4:0] ^ 5'($urandom_range(0, 3));
      q.trade_clock[5:0] = q.trade_clock[5:0] ^ 6'($urandom_range(0, 7));
      q.coupon_rate = q.coupon_rate + $urandom_range(0, 1 << 18);
      q.notional = q.notional ^ 40'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) q.open_day[16:9] = '0;
      if ($urandom_range(0, 3) == 0) q.close_day[16:9] = '0;
      if ($urandom_range(0, 2) == 0) q.trade_date[16:9] = '0;
      if ($urandom_range(0, 3) == 0) q.coupon_rate = '0;
      if ($urandom_range(0, 3) == 0) q.notional = '0;
      return q;
   endfunction

   task automatic send(input req_item_type it, input logic typed, input nearest_type want);
      req_valid <= 1'b1;
      req_func <= it.func;
      req_entry_slot <= it.slot;
      req_open_day <= it.rec.open_day;
      req_close_day <= it.rec.close_day;
      req_trade_date <= it.rec.trade_date;
      req_trade_clock <= it.rec.trade_clock;
      req_coupon_rate <= it.rec.coupon_rate;
      req_notional <= it.rec.notional;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.func == FUNC_WRITE) begin
         record_shadow[it.slot] = it.rec;
      end else begin
         nearest_q.push_back(typed ? want : predict_nearest(it.rec));
      end
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_plain(input req_item_type it);
      nearest_type unused;
      unused = '{default: '0};
      send(it, 1'b0, unused);
   endtask

   // hold until idle, then load a new scan count
   task automatic set_scan_count(input logic [10:0] n);
      req_valid <= 1'b0;
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (((scan_count > Entries) ? Entries : scan_count) + 20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_entry_count <= n;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      scan_count = n;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (nearest_q.size() == 0) begin
               $display("%0t: result with none pending: index %0d distance %0d", $time,
                  rsp_nearest_index, rsp_best_score);
               error_count++;
            end else begin
               nearest_type e;
               e = nearest_q.pop_front();
               if (rsp_nearest_index !== e.index) begin
                  $display("%0t: nearest_index expected %0d actual %0d", $time,
                     e.index, rsp_nearest_index);
                  error_count++;
               end
               if (rsp_best_score !== e.distance) begin
                  $display("%0t: best_score expected %0d actual %0d", $time,
                     e.distance, rsp_best_score);
                  error_count++;
               end
               if (rsp_none_closer !== e.none_closer) begin
                  $display("%0t: none_closer expected %0d actual %0d", $time,
                     e.none_closer, rsp_none_closer);
                  error_count++;
               end
            end
         end
         // stall pattern drifts between free flow, random and heavy
         case ((cycle_count / 500) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("weighted_nearest_record_search_top verification failed");
         $finish;
      end
   end

   initial begin
      dir_row_type  rows [$];
      req_item_type it;
      record_type   zero_rec;
      record_type   max_rec;
      record_type   rec_a;
      record_type   rec_min_rate;
      record_type   q;
      nearest_type  none_found;
      nearest_type  no_want;
      logic [10:0]  phase_counts [5];
      int           j;

      zero_rec = '{default: '0};
      max_rec = '{default: '1};
      max_rec.coupon_rate = 32'h7FFF_FFFF;
      rec_a.open_day = pack_date(120, 3, 15);
      rec_a.close_day = pack_date(125, 3, 15);
      rec_a.trade_date = pack_date(119, 11, 30);
      rec_a.trade_clock = {5'd14, 6'd30, 6'd5};
      rec_a.coupon_rate = 32'h0002_8000;
      rec_a.notional = 40'd5000000;
      rec_min_rate = zero_rec;
      rec_min_rate.coupon_rate = 32'h8000_0000;
      none_found = '{index: '0, distance: DistW'(NoneDist), none_closer: 1'b1};
      no_want = '{default: '0};

      // empty scans, then fill the low entries and the last one, and query them
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, zero_rec}, 1'b1, none_found});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'h3FF, '{default: '1}}, 1'b1, none_found});
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'd0, zero_rec}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'd1, max_rec}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'd2, rec_min_rate}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'd3, rec_a}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'd4, rec_a}, 1'b0, no_want});
      q = rec_a;
      q.open_day = 17'(q.open_day + 2);
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'd5, q}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_WRITE, 10'h3FF, max_rec}, 1'b0, no_want});
      rows.push_back('{1'b1, 11'd6, '{FUNC_QUERY, 10'd0, zero_rec}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, zero_rec}, 1'b1, '{0, 0, 0}});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, rec_a}, 1'b1, '{3, 0, 0}});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, max_rec}, 1'b1, '{1, 0, 0}});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, rec_min_rate}, 1'b1, '{2, 0, 0}});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd7, q}, 1'b0, no_want});
      q.open_day[16:9] = '0;
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, q}, 1'b0, no_want});
      q = zero_rec;
      q.coupon_rate = 32'hFFFF_FFFF;
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, q}, 1'b0, no_want});
      q = zero_rec;
      q.notional = '1;
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, q}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, '{default: '1}}, 1'b0, no_want});
      q = rec_a;
      q.trade_clock = 17'(q.trade_clock + 3);
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, q}, 1'b0, no_want});
      rows.push_back('{1'b1, 11'd0, '{FUNC_QUERY, 10'd0, zero_rec}, 1'b0, no_want});
      rows.push_back('{1'b0, 0, '{FUNC_QUERY, 10'd0, rec_a}, 1'b1, none_found});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_cfg) set_scan_count(rows[i].cnt);
         else send(rows[i].item, rows[i].typed, rows[i].want);
      end

      for (int s = 0; s < 64; s++) send_plain('{FUNC_WRITE, 10'(s), random_record()});

      phase_counts = '{11'd1, 11'd7, 11'd40, 11'd64, 11'd23};
      foreach (phase_counts[p]) begin
         set_scan_count(phase_counts[p]);
         for (int k = 0; k < 100; k++) begin
            j = $urandom_range(0, 9);
            if (j < 2) begin
               it.func = FUNC_WRITE;
               it.slot = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
               it.rec = random_record();
            end else begin
               it.func = FUNC_QUERY;
               it.slot = 10'($urandom);
               it.rec = (j == 2) ? random_record()
                  : near_query(record_shadow[$urandom_range(0, phase_counts[p] - 1)]);
            end
            send_plain(it);
         end
      end

      req_valid <= 1'b0;
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (Entries + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("weighted_nearest_record_search_top verification clean");
      end else begin
         $display("weighted_nearest_record_search_top verification failed");
      end
      $finish;
   end

endmodule
